@@ design/q2e_pkg.sv @@
// ----------------------------------------------------------------------------
// q2e_pkg
// shared constants and types for the quaternion to euler angle pipeline
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int QUAT_FRAC_BITS  = 30;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int ZFRAC           = 16;
  localparam int CORDIC_STEPS    = 20;
  localparam int NORM_STEPS      = 6;
  localparam int SQRT_STEPS      = 31;
  localparam int ATAN_LAT        = CORDIC_STEPS + NORM_STEPS + 2;
  localparam int ROUND_SH        = ZFRAC - ANGLE_FRAC_BITS;
  localparam int ANG_W           = 25;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic [61:0]             rad_t;
  typedef logic [30:0]             root_t;
  typedef logic signed [63:0]      wide_t;

  localparam ang_t HALF_TURN    = ang_t'(180 * (1 << ZFRAC));
  localparam ang_t QUARTER_TURN = ang_t'(90 * (1 << ZFRAC));

  localparam ang_t ATAN_TAB [CORDIC_STEPS] = '{
    ang_t'(2949120), ang_t'(1740967), ang_t'(919879), ang_t'(466945),
    ang_t'(234379),  ang_t'(117304),  ang_t'(58666),  ang_t'(29335),
    ang_t'(14668),   ang_t'(7334),    ang_t'(3667),   ang_t'(1833),
    ang_t'(917),     ang_t'(458),     ang_t'(229),    ang_t'(115),
    ang_t'(57),      ang_t'(29),      ang_t'(14),     ang_t'(7)
  };

endpackage

@@ design/q2e_isqrt.sv @@
// ----------------------------------------------------------------------------
// q2e_isqrt
// pipelined floor square root, one result bit per register stage
// ----------------------------------------------------------------------------
module q2e_isqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ce,
  input  logic           in_valid,
  input  q2e_pkg::rad_t  radicand,
  output logic           out_valid,
  output q2e_pkg::root_t root
);

  localparam int N = q2e_pkg::SQRT_STEPS;

  logic        vld_r    [N];
  logic [61:0] val_r    [N];
  logic [31:0] rem_r    [N];
  logic [30:0] root_r   [N];
  logic        vld_src  [N];
  logic [61:0] val_nxt  [N];
  logic [31:0] rem_nxt  [N];
  logic [30:0] root_nxt [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [61:0] v_src;
    logic [31:0] r_src;
    logic [30:0] q_src;
    logic [33:0] remx;
    logic [34:0] trial;
    if (k == 0) begin : g_first
      assign v_src      = radicand;
      assign r_src      = '0;
      assign q_src      = '0;
      assign vld_src[k] = in_valid;
    end else begin : g_next
      assign v_src      = val_r[k-1];
      assign r_src      = rem_r[k-1];
      assign q_src      = root_r[k-1];
      assign vld_src[k] = vld_r[k-1];
    end
    assign remx        = {r_src, v_src[61:60]};
    assign trial       = {1'b0, remx} - {2'b00, q_src, 2'b01};
    assign val_nxt[k]  = {v_src[59:0], 2'b00};
    assign rem_nxt[k]  = trial[34] ? remx[31:0] : trial[31:0];
    assign root_nxt[k] = {q_src[29:0], ~trial[34]};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ce) begin
        vld_r[k] <= vld_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < N; k++) begin
        val_r[k]  <= val_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign root      = root_r[N-1];

endmodule

@@ design/q2e_atan2.sv @@
// ----------------------------------------------------------------------------
// q2e_atan2
// pipelined atan2: magnitude, normalize, cordic vectoring, quadrant fix
// ----------------------------------------------------------------------------
module q2e_atan2 (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ce,
  input  logic          in_valid,
  input  q2e_pkg::wide_t x,
  input  q2e_pkg::wide_t y,
  output logic          out_valid,
  output q2e_pkg::ang_t angle
);

  localparam int LAT = q2e_pkg::ATAN_LAT;
  localparam int NS  = q2e_pkg::NORM_STEPS;
  localparam int CS  = q2e_pkg::CORDIC_STEPS;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic zero;
  } flag_t;

  logic  vld_r [LAT];
  flag_t fl_r  [LAT-1];
  flag_t fl_in;

  logic [63:0] ax_r, ay_r;
  logic [63:0] nx_r [NS];
  logic [63:0] ny_r [NS];
  logic [63:0] nx_nxt [NS];
  logic [63:0] ny_nxt [NS];

  logic signed [32:0] cx_r [CS];
  logic signed [32:0] cy_r [CS];
  q2e_pkg::ang_t      cz_r [CS];
  logic signed [32:0] cx_nxt [CS];
  logic signed [32:0] cy_nxt [CS];
  q2e_pkg::ang_t      cz_nxt [CS];

  q2e_pkg::ang_t ang_r, ang_a, ang_b, ang_nxt;

  assign fl_in.xneg = x[63];
  assign fl_in.yneg = y[63];
  assign fl_in.zero = (x == '0) && (y == '0);

  // normalize so the leading one of the larger magnitude sits at bit 63
  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int SH = 32 >> j;
    logic [63:0] sx, sy, ow;
    if (j == 0) begin : g_first
      assign sx = ax_r;
      assign sy = ay_r;
    end else begin : g_next
      assign sx = nx_r[j-1];
      assign sy = ny_r[j-1];
    end
    assign ow        = sx | sy;
    assign nx_nxt[j] = (ow[63 -: SH] == '0) ? (sx << SH) : sx;
    assign ny_nxt[j] = (ow[63 -: SH] == '0) ? (sy << SH) : sy;
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    logic signed [32:0] sx, sy, dx, dy;
    q2e_pkg::ang_t      sz;
    if (i == 0) begin : g_first
      assign sx = $signed({3'b000, nx_r[NS-1][63:34]});
      assign sy = $signed({3'b000, ny_r[NS-1][63:34]});
      assign sz = '0;
    end else begin : g_next
      assign sx = cx_r[i-1];
      assign sy = cy_r[i-1];
      assign sz = cz_r[i-1];
    end
    assign dx        = sy >>> i;
    assign dy        = sx >>> i;
    assign cx_nxt[i] = sy[32] ? sx - dx : sx + dx;
    assign cy_nxt[i] = sy[32] ? sy + dy : sy - dy;
    assign cz_nxt[i] = sy[32] ? sz - q2e_pkg::ATAN_TAB[i] : sz + q2e_pkg::ATAN_TAB[i];
  end

  always_comb begin
    ang_a   = fl_r[LAT-2].xneg ? q2e_pkg::HALF_TURN - cz_r[CS-1] : cz_r[CS-1];
    ang_b   = fl_r[LAT-2].yneg ? -ang_a : ang_a;
    ang_nxt = fl_r[LAT-2].zero ? '0 : ang_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (ce) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fl_r[0] <= fl_in;
      for (int k = 1; k < LAT - 1; k++) begin
        fl_r[k] <= fl_r[k-1];
      end
      ax_r <= x[63] ? 64'(-x) : x;
      ay_r <= y[63] ? 64'(-y) : y;
      for (int j = 0; j < NS; j++) begin
        nx_r[j] <= nx_nxt[j];
        ny_r[j] <= ny_nxt[j];
      end
      for (int i = 0; i < CS; i++) begin
        cx_r[i] <= cx_nxt[i];
        cy_r[i] <= cy_nxt[i];
        cz_r[i] <= cz_nxt[i];
      end
      ang_r <= ang_nxt;
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign angle     = ang_r;

endmodule

@@ design/quaternion_to_euler_angles_unit.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// roll, pitch and yaw from the vector part of a unit quaternion
// ----------------------------------------------------------------------------
// input beats carry q1, q2, q3 (Q2.30) and an accuracy word in in_tdata and
// the quaternion-present flag in in_tuser; beats with the flag low are taken
// and dropped. each kept beat gives one output beat with roll, pitch and yaw
// in 1/128 degree, the accuracy copy, and the clamp and pole flags in
// out_tuser.
// a result passes load, squares, norm, a 31-stage q0 root, scalar products,
// sine terms, a product stage, a second 31-stage root, a 28-stage atan2
// (magnitude, normalize, 20 cordic steps and quadrant fix).
// one beat is taken per cycle when the output keeps up.
// reset clears all valid bits; data registers are not reset.
// when out_tready is low and a result waits, the pipeline keeps moving as
// long as its last stage is empty, then holds every stage as a whole.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // qx_part, qy_part, qz_part, heading_accuracy
  input  logic [0:0]   in_tuser,   // has_quat
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // roll_deg, pitch_deg, yaw_deg, accuracy_out, pad
  output logic [1:0]   out_tuser   // scalar_clamped, pitch_saturated
);

  localparam int F    = q2e_pkg::QUAT_FRAC_BITS;
  localparam int NSQ  = q2e_pkg::SQRT_STEPS;
  localparam int NAT  = q2e_pkg::ATAN_LAT;
  localparam int RYD  = NSQ + 1;
  localparam int RSH  = (2 * F > 30) ? 2 * F - 30 : 0;
  localparam int LSH  = (2 * F < 30) ? 30 - 2 * F : 0;

  localparam logic signed [31:0] Q_LIM  = 32'sd1 <<< F;
  localparam logic [61:0]        ONE_Q  = 62'd1 << (2 * F);
  localparam logic signed [63:0] ONE_S  = 64'sd1 <<< (2 * F);
  localparam logic [30:0]        FULL   = 31'd1 << 30;
  localparam logic [14:0]        POLE_P = 15'(90 << q2e_pkg::ANGLE_FRAC_BITS);
  localparam logic [14:0]        POLE_N = 15'(-(90 << q2e_pkg::ANGLE_FRAC_BITS));

  typedef struct packed {
    logic signed [31:0] q1;
    logic signed [31:0] q2;
    logic signed [31:0] q3;
    logic signed [61:0] p12;
    logic signed [61:0] p23;
    logic signed [61:0] p31;
    logic [63:0]        xr;
    logic [63:0]        xy;
    logic [15:0]        acc;
    logic               clamped;
  } sb_t;

  typedef struct packed {
    logic [30:0] mag;
    logic        sat;
    logic        sneg;
    logic [15:0] acc;
    logic        clamped;
  } pb_t;

  typedef struct packed {
    q2e_pkg::ang_t roll;
    q2e_pkg::ang_t yaw;
  } ry_t;

  function automatic logic signed [31:0] sat_q(input logic signed [31:0] v);
    if (v > Q_LIM) begin
      return Q_LIM;
    end else if (v < -Q_LIM) begin
      return -Q_LIM;
    end
    return v;
  endfunction

  function automatic logic [15:0] rnd(input q2e_pkg::ang_t z);
    q2e_pkg::ang_t t;
    t = (z + q2e_pkg::ang_t'(1 << (q2e_pkg::ROUND_SH - 1))) >>> q2e_pkg::ROUND_SH;
    return t[15:0];
  endfunction

  logic ce, fin_valid, out_valid_r;
  logic [63:0] out_tdata_r;
  logic [1:0]  out_tuser_r;
  logic        pitch_valid;

  // stage 1: load and saturate
  logic               v1_r;
  logic signed [31:0] q1_r, q2_r, q3_r;
  logic [15:0]        acc1_r;

  // stage 2: squares and cross products
  logic               v2_r;
  logic [60:0]        p11_r, p22_r, p33_r;
  logic signed [61:0] p12_r, p23_r, p31_r;
  logic signed [31:0] q1b_r, q2b_r, q3b_r;
  logic [15:0]        acc2_r;
  logic signed [63:0] m11, m22, m33, m12, m23, m31;

  // stage 3: norm, clamp, cosine terms
  logic               v3_r;
  q2e_pkg::rad_t      rad3_r;
  sb_t                sb3_r, sb3_nxt;
  logic [61:0]        sq;
  logic [63:0]        s12, s23;
  logic               clamp3;
  sb_t                sbd_r [NSQ];

  // stage 4: q0 products
  logic               v4;
  q2e_pkg::root_t     q0;
  logic signed [31:0] q0s;
  logic signed [63:0] m01, m02, m03;
  logic               v4_r;
  logic signed [61:0] p01_r, p02_r, p03_r;
  sb_t                sb4_r;

  // stage 5: sine terms and pitch magnitude
  logic               v5_r;
  q2e_pkg::wide_t     xr5_r, xy5_r, yr5_r, yy5_r;
  pb_t                pb5_r, pb5_nxt;
  q2e_pkg::wide_t     yr5, yy5, s5;
  logic [63:0]        s5_abs, mag_w;

  // stage 6: cosine product for the pitch root
  logic               v6_r;
  q2e_pkg::rad_t      prod6_r;
  pb_t                pb6_r;
  logic [31:0]        lo6, hi6;
  logic [63:0]        pr6;
  pb_t                pbd_r [NSQ];
  pb_t                pbe_r [NAT];

  logic               c_valid;
  q2e_pkg::root_t     c_root;
  q2e_pkg::ang_t      roll_a, yaw_a, pitch_a, pitch_z;
  ry_t                ry_r [RYD];
  ry_t                ry_in;
  pb_t                pb_f;

  assign fin_valid = pitch_valid;

  assign ce        = !fin_valid || !out_valid_r || out_tready;
  assign in_tready = ce;

  always_comb begin
    m11 = 64'(q1_r) * 64'(q1_r);
    m22 = 64'(q2_r) * 64'(q2_r);
    m33 = 64'(q3_r) * 64'(q3_r);
    m12 = 64'(q1_r) * 64'(q2_r);
    m23 = 64'(q2_r) * 64'(q3_r);
    m31 = 64'(q3_r) * 64'(q1_r);
  end

  always_comb begin
    sq              = 62'(p11_r) + 62'(p22_r) + 62'(p33_r);
    clamp3          = sq > ONE_Q;
    s12             = 64'(p11_r) + 64'(p22_r);
    s23             = 64'(p22_r) + 64'(p33_r);
    sb3_nxt.q1      = q1b_r;
    sb3_nxt.q2      = q2b_r;
    sb3_nxt.q3      = q3b_r;
    sb3_nxt.p12     = p12_r;
    sb3_nxt.p23     = p23_r;
    sb3_nxt.p31     = p31_r;
    sb3_nxt.xr      = 64'(ONE_Q) - (s12 << 1);
    sb3_nxt.xy      = 64'(ONE_Q) - (s23 << 1);
    sb3_nxt.acc     = acc2_r;
    sb3_nxt.clamped = clamp3;
  end

  q2e_isqrt u_q0_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v3_r),
    .radicand  (rad3_r),
    .out_valid (v4),
    .root      (q0)
  );

  always_comb begin
    q0s = $signed({1'b0, q0});
    m01 = 64'(q0s) * 64'(sbd_r[NSQ-1].q1);
    m02 = 64'(q0s) * 64'(sbd_r[NSQ-1].q2);
    m03 = 64'(q0s) * 64'(sbd_r[NSQ-1].q3);
  end

  always_comb begin
    yr5             = (64'(p01_r) + 64'(sb4_r.p23)) <<< 1;
    yy5             = (64'(p03_r) + 64'(sb4_r.p12)) <<< 1;
    s5              = (64'(p02_r) - 64'(sb4_r.p31)) <<< 1;
    s5_abs          = s5[63] ? 64'(-s5) : s5;
    mag_w           = (s5_abs >> RSH) << LSH;
    pb5_nxt.mag     = (mag_w > 64'(FULL)) ? FULL : mag_w[30:0];
    pb5_nxt.sat     = (s5 >= ONE_S) || (s5 <= -ONE_S);
    pb5_nxt.sneg    = s5[63];
    pb5_nxt.acc     = sb4_r.acc;
    pb5_nxt.clamped = sb4_r.clamped;
  end

  q2e_atan2 u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v5_r),
    .x         (xr5_r),
    .y         (yr5_r),
    .out_valid (),
    .angle     (roll_a)
  );

  q2e_atan2 u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v5_r),
    .x         (xy5_r),
    .y         (yy5_r),
    .out_valid (),
    .angle     (yaw_a)
  );

  always_comb begin
    lo6 = 32'(FULL) - 32'(pb5_r.mag);
    hi6 = 32'(FULL) + 32'(pb5_r.mag);
    pr6 = 64'(lo6) * 64'(hi6);
  end

  q2e_isqrt u_cos_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v6_r),
    .radicand  (prod6_r),
    .out_valid (c_valid),
    .root      (c_root)
  );

  q2e_atan2 u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (c_valid),
    .x         ($signed({33'd0, c_root})),
    .y         ($signed({33'd0, pbd_r[NSQ-1].mag})),
    .out_valid (pitch_valid),
    .angle     (pitch_a)
  );

  assign ry_in.roll = roll_a;
  assign ry_in.yaw  = yaw_a;
  assign pb_f       = pbe_r[NAT-1];

  always_comb begin
    if (pb_f.sat) begin
      pitch_z = pb_f.sneg ? -q2e_pkg::QUARTER_TURN : q2e_pkg::QUARTER_TURN;
    end else begin
      pitch_z = pb_f.sneg ? -pitch_a : pitch_a;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_tvalid && in_tuser[0];
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v4;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      q1_r    <= sat_q(in_tdata[31:0]);
      q2_r    <= sat_q(in_tdata[63:32]);
      q3_r    <= sat_q(in_tdata[95:64]);
      acc1_r  <= in_tdata[111:96];

      p11_r   <= m11[60:0];
      p22_r   <= m22[60:0];
      p33_r   <= m33[60:0];
      p12_r   <= m12[61:0];
      p23_r   <= m23[61:0];
      p31_r   <= m31[61:0];
      q1b_r   <= q1_r;
      q2b_r   <= q2_r;
      q3b_r   <= q3_r;
      acc2_r  <= acc1_r;

      rad3_r  <= clamp3 ? '0 : (ONE_Q - sq);
      sb3_r   <= sb3_nxt;
      sbd_r[0] <= sb3_r;
      for (int k = 1; k < NSQ; k++) begin
        sbd_r[k] <= sbd_r[k-1];
      end

      p01_r   <= m01[61:0];
      p02_r   <= m02[61:0];
      p03_r   <= m03[61:0];
      sb4_r   <= sbd_r[NSQ-1];

      xr5_r   <= sb4_r.xr;
      xy5_r   <= sb4_r.xy;
      yr5_r   <= yr5;
      yy5_r   <= yy5;
      pb5_r   <= pb5_nxt;

      prod6_r <= pr6[61:0];
      pb6_r   <= pb5_r;
      pbd_r[0] <= pb6_r;
      for (int k = 1; k < NSQ; k++) begin
        pbd_r[k] <= pbd_r[k-1];
      end
      pbe_r[0] <= pbd_r[NSQ-1];
      for (int k = 1; k < NAT; k++) begin
        pbe_r[k] <= pbe_r[k-1];
      end
      ry_r[0] <= ry_in;
      for (int k = 1; k < RYD; k++) begin
        ry_r[k] <= ry_r[k-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce && fin_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce && fin_valid) begin
      out_tdata_r <= {1'b0, pb_f.acc, rnd(ry_r[RYD-1].yaw), 15'(rnd(pitch_z)),
                      rnd(ry_r[RYD-1].roll)};
      out_tuser_r <= {pb_f.sat, pb_f.clamped};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_pole_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> ((out_tdata[30:16] == POLE_P) ||
                                      (out_tdata[30:16] == POLE_N)))
    else $error("saturated pitch is not at a pole");
  a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser[0]) |=> !v1_r)
    else $error("beat without quaternion entered the pipeline");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ce |=> ($stable(v1_r) && $stable(v3_r) && $stable(v6_r)))
    else $error("pipeline moved while stalled");
`endif

endmodule
